// ----- design/hrl_pkg.sv -----
// Shared widths, constants and a helper function for the heading rate limiter.
package hrl_pkg;

	// field widths
	localparam int COORD_W = 32;
	localparam int ANG_W = 16;
	localparam int RATE_W = 24;

	// serial multiply-accumulate unit: three 24-bit multiplicands, 25-bit multipliers
	localparam int DQ_W = 24;
	localparam int MB_W = 25;
	localparam int HI_W = DQ_W + 2;
	localparam int PROD_W = HI_W + MB_W;
	localparam int CNT_W = 5;

	// square root unit
	localparam int RAD_W = 50;
	localparam int ROOT_W = RAD_W / 2;
	localparam int REM_W = ROOT_W + 1;

	// allowed turn
	localparam int SAT_LSB = 16;
	localparam int SAT_MSB = 32;

	localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(1024);

	// magnitude of a coordinate difference in 1/256 m units
	function automatic logic [DQ_W-1:0] diff_q8(input logic [COORD_W-1:0] a,
			input logic [COORD_W-1:0] b);
		logic [COORD_W:0] d;
		logic [COORD_W:0] m;
		d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
		m = d[COORD_W] ? (~d + 1'b1) : d;
		return m[COORD_W-1:8];
	endfunction

endpackage

// ----- design/hrl_if.sv -----
// Handshake channels for waypoints, headings and the rate register.
interface hrl_wp_if;
	import hrl_pkg::*;
	logic valid;
	logic ready;
	logic [COORD_W-1:0] waypoint_x;
	logic [COORD_W-1:0] waypoint_y;
	logic [COORD_W-1:0] waypoint_z;
	logic [ANG_W-1:0] heading_in;
	logic first_point;

	modport source (output valid, waypoint_x, waypoint_y, waypoint_z, heading_in,
		first_point, input ready);
	modport sink (input valid, waypoint_x, waypoint_y, waypoint_z, heading_in,
		first_point, output ready);
endinterface

interface hrl_hd_if;
	import hrl_pkg::*;
	logic valid;
	logic ready;
	logic [ANG_W-1:0] heading_out;
	logic was_limited;

	modport source (output valid, heading_out, was_limited, input ready);
	modport sink (input valid, heading_out, was_limited, output ready);
endinterface

interface hrl_cfg_if;
	import hrl_pkg::*;
	logic valid;
	logic ready;
	logic [RATE_W-1:0] max_turn_per_metre;

	modport source (output valid, max_turn_per_metre, input ready);
	modport sink (input valid, max_turn_per_metre, output ready);
endinterface

// ----- design/hrl_sermac.sv -----
// Bit-serial sum of three products, one multiplier bit per cycle, LSB first.
module hrl_sermac
	import hrl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DQ_W-1:0]   a0,
	input  logic [DQ_W-1:0]   a1,
	input  logic [DQ_W-1:0]   a2,
	input  logic [MB_W-1:0]   b0,
	input  logic [MB_W-1:0]   b1,
	input  logic [MB_W-1:0]   b2,
	output logic              done,
	output logic [PROD_W-1:0] result
);

	logic [DQ_W-1:0] a0_q, a1_q, a2_q;
	logic [MB_W-1:0] b0_q, b1_q, b2_q;
	logic [HI_W-1:0] hi_q;
	logic [MB_W-1:0] lo_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q, done_q;
	logic [HI_W:0] sum;

	// partial sum: upper accumulator plus the gated multiplicands
	assign sum = {1'b0, hi_q}
		+ (b0_q[0] ? (HI_W+1)'(a0_q) : '0)
		+ (b1_q[0] ? (HI_W+1)'(a1_q) : '0)
		+ (b2_q[0] ? (HI_W+1)'(a2_q) : '0);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(MB_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// datapath: shift products right one bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			a0_q <= a0;
			a1_q <= a1;
			a2_q <= a2;
			b0_q <= b0;
			b1_q <= b1;
			b2_q <= b2;
			hi_q <= '0;
			lo_q <= '0;
		end else if (busy_q) begin
			b0_q <= b0_q >> 1;
			b1_q <= b1_q >> 1;
			b2_q <= b2_q >> 1;
			hi_q <= sum[HI_W:1];
			lo_q <= {sum[0], lo_q[MB_W-1:1]};
		end
	end

	assign done = done_q;
	assign result = {hi_q, lo_q};

endmodule

// ----- design/hrl_isqrt.sv -----
// Restoring integer square root, one root bit per cycle.
module hrl_isqrt
	import hrl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [RAD_W-1:0]  radicand,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	logic [RAD_W-1:0] rad_q;
	logic [REM_W-1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q, done_q;
	logic [REM_W+1:0] r2;
	logic [REM_W+1:0] trial;
	logic [REM_W+1:0] diff;
	logic fits;

	// trial subtraction of (4*root + 1) from the shifted remainder
	assign r2 = {rem_q, rad_q[RAD_W-1:RAD_W-2]};
	assign trial = (REM_W+2)'({root_q, 2'b01});
	assign fits = r2 >= trial;
	assign diff = r2 - trial;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(ROOT_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// datapath: radicand shifts out two bits per cycle, MSB first
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= radicand;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[RAD_W-3:0], 2'b00};
			if (fits) begin
				rem_q <= diff[REM_W-1:0];
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q <= r2[REM_W-1:0];
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ----- design/heading_rate_limiter.sv -----
// Heading slew-rate limiter over a path of waypoints (top level).
//
//  channel    | role   | word
//  -----------+--------+-------------------------------------------------
//  waypoint   | sink   | waypoint_x/y/z, heading_in, first_point
//  heading    | source | heading_out, was_limited
//  cfg        | sink   | max_turn_per_metre (always ready)
//
// A first point goes straight to the final stage; any other point runs the
// serial sum of squares, then the square root, then the scale multiply on
// the same serial multiply unit, with hand-over between them.
// One waypoint is in work at a time; the next is taken while the result waits.
// Reset clears stored position and heading to zero and the rate to 1024.
// A stalled result holds the final stage until the heading channel takes it.
module heading_rate_limiter
	import hrl_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	hrl_cfg_if.sink    cfg,
	hrl_wp_if.sink     waypoint,
	hrl_hd_if.source   heading
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SQ    = 5'b00010,
		S_ROOT  = 5'b00100,
		S_SCALE = 5'b01000,
		S_FIN   = 5'b10000
	} state_t;

	state_t state_q;

	logic [RATE_W-1:0] rate_q;
	logic [COORD_W-1:0] x_q, y_q, z_q;
	logic [COORD_W-1:0] prev_x_q, prev_y_q, prev_z_q;
	logic [ANG_W-1:0] hin_q, prev_h_q;
	logic first_q;
	logic mac_start_q;
	logic out_valid_q;
	logic [ANG_W-1:0] out_h_q;
	logic out_lim_q;

	logic accept;
	logic mac_start, mac_done, sq_done;
	logic [DQ_W-1:0] dx, dy, dz;
	logic [DQ_W-1:0] a0, a1, a2;
	logic [MB_W-1:0] b0, b1, b2;
	logic [PROD_W-1:0] mac_result;
	logic root_start, root_done;
	logic [ROOT_W-1:0] root;
	logic fin_load;
	logic [ANG_W-1:0] allowed, draw, mag, hout;
	logic neg, limited;

	assign accept = waypoint.valid && waypoint.ready;
	assign waypoint.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	// rate register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_RESET;
		end else if (cfg.valid) begin
			rate_q <= cfg.max_turn_per_metre;
		end
	end

	// waypoint capture
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= waypoint.waypoint_x;
			y_q <= waypoint.waypoint_y;
			z_q <= waypoint.waypoint_z;
			hin_q <= waypoint.heading_in;
			first_q <= waypoint.first_point;
		end
	end

	// segment differences against the stored position
	assign dx = diff_q8(x_q, prev_x_q);
	assign dy = diff_q8(y_q, prev_y_q);
	assign dz = diff_q8(z_q, prev_z_q);

	// multiply unit operands: squares first, then length times rate
	assign sq_done = mac_done && (state_q == S_SQ);
	assign root_start = sq_done;
	assign mac_start = mac_start_q || (root_done && (state_q == S_ROOT));

	always_comb begin
		if (state_q == S_ROOT) begin
			a0 = rate_q;
			b0 = root;
			a1 = '0;
			b1 = '0;
			a2 = '0;
			b2 = '0;
		end else begin
			a0 = dx;
			b0 = MB_W'(dx);
			a1 = dy;
			b1 = MB_W'(dy);
			a2 = dz;
			b2 = MB_W'(dz);
		end
	end

	hrl_sermac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mac_start),
		.a0     (a0),
		.a1     (a1),
		.a2     (a2),
		.b0     (b0),
		.b1     (b1),
		.b2     (b2),
		.done   (mac_done),
		.result (mac_result)
	);

	hrl_isqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (mac_result[RAD_W-1:0]),
		.done     (root_done),
		.root     (root)
	);

	// allowed turn, saturated to the angle range
	assign allowed = (|mac_result[PROD_W-1:SAT_MSB]) ? '1
		: mac_result[SAT_MSB-1:SAT_LSB];

	// wrapped heading change and limiting
	assign draw = hin_q - prev_h_q;
	assign neg = draw[ANG_W-1];
	assign mag = neg ? (~draw + 1'b1) : draw;
	assign limited = !first_q && (mag > allowed);
	always_comb begin
		if (!limited) begin
			hout = hin_q;
		end else if (neg) begin
			hout = prev_h_q - allowed;
		end else begin
			hout = prev_h_q + allowed;
		end
	end

	assign fin_load = (state_q == S_FIN) && (!out_valid_q || heading.ready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mac_start_q <= 1'b0;
		end else begin
			mac_start_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (waypoint.first_point) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_SQ;
							mac_start_q <= 1'b1;
						end
					end
				end
				S_SQ: begin
					if (mac_done) state_q <= S_ROOT;
				end
				S_ROOT: begin
					if (root_done) state_q <= S_SCALE;
				end
				S_SCALE: begin
					if (mac_done) state_q <= S_FIN;
				end
				S_FIN: begin
					if (fin_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// previous waypoint and heading
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q <= '0;
			prev_y_q <= '0;
			prev_z_q <= '0;
			prev_h_q <= '0;
		end else if (fin_load) begin
			prev_x_q <= x_q;
			prev_y_q <= y_q;
			prev_z_q <= z_q;
			prev_h_q <= hout;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_load) begin
			out_valid_q <= 1'b1;
		end else if (heading.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			out_h_q <= hout;
			out_lim_q <= limited;
		end
	end

	assign heading.valid = out_valid_q;
	assign heading.heading_out = out_h_q;
	assign heading.was_limited = out_lim_q;

endmodule
